### design/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned LenOffset   = 56;
  localparam int unsigned Rounds      = 64;
  localparam int unsigned DigestWords = 8;
  localparam logic [7:0]  PadByte     = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_FINISH,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic start_block;
    logic pad_write;
    logic pad_final;
    logic emit_word;
    logic reinit;
  } dp_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic busy;
    logic block_full;
    logic last_word;
  } dp_status_t;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    return h[idx];
  endfunction

endpackage

### design/sha_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, message_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, message_byte, byte_present, end_of_message, output ready);
  modport monitor (input valid, ready, message_byte, byte_present, end_of_message);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;
  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink (input valid, digest_word, word_number, final_word, output ready);
  modport monitor (input valid, ready, digest_word, word_number, final_word);
endinterface

### design/sha_datapath.sv
`timescale 1ns / 1ps
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  byte_i,
  output dp_status_t  status_o,
  output logic [5:0]  fill_o,
  output logic [31:0] digest_o,
  output logic [2:0]  word_idx_o
);

  logic [31:0] w_q [16];
  logic [31:0] r_q [8];
  logic [31:0] h_q [8];
  logic [60:0] count_q;
  logic [5:0]  fill_q;
  logic [5:0]  round_q;
  logic        run_q;
  logic [2:0]  word_q;

  logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new, wt;
  logic [63:0] bit_len;

  assign wt = w_q[0];
  assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
  assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
            ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign big1 = {r_q[4][5:0], r_q[4][31:6]} ^ {r_q[4][10:0], r_q[4][31:11]}
              ^ {r_q[4][24:0], r_q[4][31:25]};
  assign ch   = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
  assign t1   = r_q[7] + big1 + ch + round_const(round_q) + wt;
  assign big0 = {r_q[0][1:0], r_q[0][31:2]} ^ {r_q[0][12:0], r_q[0][31:13]}
              ^ {r_q[0][21:0], r_q[0][31:22]};
  assign maj  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
  assign t2   = big0 + maj;
  assign bit_len = {count_q, 3'b000};

  // Write one byte into the word buffer at the current fill position.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                            input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (pos)
      2'd0:    r[31:24] = b;
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      default: r[7:0]   = b;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fill_q  <= '0;
      round_q <= '0;
      run_q   <= 1'b0;
      word_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      if (cmd_i.take_byte) begin
        count_q <= count_q + 61'd1;
        fill_q  <= fill_q + 6'd1;
      end
      if (cmd_i.pad_write) begin
        // Zero fill, or the 0x80 marker at the message's end position.
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.start_block) begin
        run_q   <= 1'b1;
        round_q <= '0;
      end
      if (run_q) begin
        round_q <= round_q + 6'd1;
        if (round_q == 6'(Rounds - 1)) begin
          // The chain takes the working values as they leave the last round.
          run_q  <= 1'b0;
          h_q[0] <= h_q[0] + t1 + t2;
          h_q[1] <= h_q[1] + r_q[0];
          h_q[2] <= h_q[2] + r_q[1];
          h_q[3] <= h_q[3] + r_q[2];
          h_q[4] <= h_q[4] + r_q[3] + t1;
          h_q[5] <= h_q[5] + r_q[4];
          h_q[6] <= h_q[6] + r_q[5];
          h_q[7] <= h_q[7] + r_q[6];
        end
      end
      if (cmd_i.emit_word) word_q <= word_q + 3'd1;
      if (cmd_i.reinit) begin
        count_q <= '0;
        fill_q  <= '0;
        word_q  <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      end
    end
  end

  // Message schedule and working registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0], byte_i);
    end else if (cmd_i.pad_write) begin
      w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0],
                                   cmd_i.pad_final ? PadByte : 8'h00);
    end else if (cmd_i.start_block && fill_q == 6'(LenOffset) && !cmd_i.pad_final) begin
      // Final block: place the bit length in the last two words.
      w_q[14] <= bit_len[63:32];
      w_q[15] <= bit_len[31:0];
    end
    if (cmd_i.start_block) begin
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end
    if (run_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

  assign status_o.busy            = run_q;
  assign status_o.block_full      = (fill_q == 6'(BlockBytes - 1));
  assign status_o.last_word       = (word_q == 3'(DigestWords - 1));
  assign fill_o     = fill_q;
  assign digest_o   = h_q[word_q];
  assign word_idx_o = word_q;

endmodule

### design/sha_ctrl.sv
`timescale 1ns / 1ps
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_byte_i,
  input  logic       in_end_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  input  logic [5:0] fill_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        end_q, end_d;
  logic        marked_q, marked_d;
  logic        fire;

  assign fire = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d  = state_q;
    end_d    = end_q;
    marked_d = marked_q;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          end_d    = in_end_i;
          marked_d = 1'b0;
          if (in_byte_i && status_i.block_full) state_d = ST_COMPRESS;
          else if (in_end_i) state_d = ST_PAD;
        end
      end
      ST_COMPRESS: begin
        // Only the block holding the length leaves the fill at the length offset.
        if (!status_i.busy && !cmd_o.start_block) begin
          if (end_q && (!marked_q || fill_i != 6'(LenOffset))) state_d = ST_PAD;
          else if (end_q) state_d = ST_EMIT;
          else state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (!marked_q) marked_d = 1'b1;
        if (marked_q && fill_i == 6'(LenOffset)) state_d = ST_FINISH;
        else if (marked_q && fill_i == 6'(BlockBytes - 1)) state_d = ST_COMPRESS;
        else if (!marked_q && status_i.block_full) state_d = ST_COMPRESS;
        if (!marked_q && status_i.block_full) marked_d = 1'b1;
      end
      ST_FINISH: state_d = ST_COMPRESS;
      ST_EMIT: begin
        if (out_ready_i && status_i.last_word) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = fire && in_byte_i;
        cmd_o.start_block = fire && in_byte_i && status_i.block_full;
      end
      ST_COMPRESS: ;
      ST_PAD: begin
        cmd_o.pad_write = !(marked_q && fill_i == 6'(LenOffset));
        cmd_o.pad_final = !marked_q;
        cmd_o.start_block = (status_i.block_full);
      end
      ST_FINISH: begin
        cmd_o.start_block = 1'b1;
      end
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_word = out_ready_i;
        cmd_o.reinit    = out_ready_i && status_i.last_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      end_q    <= 1'b0;
      marked_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      end_q    <= end_d;
      marked_q <= marked_d;
    end
  end

endmodule

### design/sha256_message_hasher.sv
`timescale 1ns / 1ps
// SHA-256 hasher over a byte stream.
// Input channel in_if: one transaction carries at most one message byte
// (byte_present) and an end-of-message mark. A byte that completes a
// 64-byte block starts a compression of 64 rounds, one per cycle; the next
// input is taken only after that compression has finished. Other
// transactions without an end mark are accepted without a stall.
// At end of message the block writes the padding one byte per cycle into
// the schedule buffer (pausing while a block is compressed if an extra block
// is needed), loads the bit length and runs the final compression.
// Output channel out_if then presents the eight digest words, word 0
// first, one per accepted transaction; final_word marks word 7. The first
// word appears once the final compression has finished.
// A stalled receiver simply holds the current word; no input is accepted
// until all eight words have gone out, after which the chain value and
// length reset.
// Reset (rst_ni low, asynchronous) loads the initial hash values, clears
// the length and returns to the idle state ready for a new message.
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [5:0] fill;
  logic [31:0] digest;
  logic [2:0]  word_idx;

  sha_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .byte_i     (in_if.message_byte),
    .status_o   (status),
    .fill_o     (fill),
    .digest_o   (digest),
    .word_idx_o (word_idx)
  );

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_byte_i   (in_if.byte_present),
    .in_end_i    (in_if.end_of_message),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .fill_i      (fill),
    .cmd_o       (cmd)
  );

  assign out_if.digest_word = digest;
  assign out_if.word_number = word_idx;
  assign out_if.final_word  = status.last_word;

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken during digest output");
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.final_word) |-> (out_if.word_number == 3'd7))
    else $error("final word mismatch");
  a_busy_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !in_if.ready) else $error("input taken during compression");
`endif

endmodule
